### src/mceg_pkg.sv
// ----------------------------------------------------------------------------
// mceg_pkg
// Shared types, constants and the key note table of the MIDI controller
// event generator.
// ----------------------------------------------------------------------------
package mceg_pkg;

  // Field widths fixed by the item format
  localparam int MASK_BITS = 7;   // key bits carried in one scan
  localparam int AXIS_W    = 16;  // signed Q1.14 joystick sample
  localparam int DZ_W      = 15;  // dead zone register
  localparam int MIDI_W    = 7;   // one MIDI data byte
  localparam int BEND_W    = 14;  // pitch bend value

  localparam logic signed [AXIS_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [AXIS_W-1:0] MINUS_ONE_Q = -16'sd16384;
  localparam logic [BEND_W-1:0]        BEND_CENTRE = 14'd8192;
  localparam logic [BEND_W:0]          BEND_MAX    = 15'd16383;
  localparam logic [MIDI_W-1:0]        CC_MODULATION = 7'd1;

  // Reset values of the configuration registers
  localparam logic [DZ_W-1:0]   DEADBAND_RST = 15'd819;
  localparam logic [MIDI_W-1:0] VELOCITY_RST = 7'd100;

  // Register select, taken from paddr bit 2
  localparam logic REG_DEADBAND = 1'b0;
  localparam logic REG_VELOCITY = 1'b1;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_BEND     = 2'd2,
    KIND_CC       = 2'd3
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t         kind;
    logic [MIDI_W-1:0] data1;
    logic [MIDI_W-1:0] data2;
  } evt_t;

  typedef struct packed {
    logic chg;
    evt_t evt;
  } lane_res_t;

  // Fixed note of each key; keys without an input bit default to middle C
  function automatic logic [MIDI_W-1:0] key_note(input int unsigned idx);
    logic [MIDI_W-1:0] n;
    case (idx)
      0:       n = 7'd60;
      1:       n = 7'd62;
      2:       n = 7'd64;
      3:       n = 7'd65;
      4:       n = 7'd61;
      5:       n = 7'd63;
      6:       n = 7'd66;
      default: n = 7'd60;
    endcase
    return n;
  endfunction

endpackage

### src/midi_controller_event_generator_core.sv
// ----------------------------------------------------------------------------
// midi_controller_event_generator_core
// Turns controller scans (key mask, joystick X/Y) into MIDI note, pitch bend
// and modulation events.
// ----------------------------------------------------------------------------
// Path: a scan item waits in the input register, its events in the event
//   buffer, and each event leaves through the output register.
// Throughput: a scan produces N events, N <= 9; the single output emitter
//   sends one event per cycle while out_tready does not stall it.
// Reset (synchronous, rst_n low): keys released, bend centred at 8192,
//   modulation 0, dead zone 819, velocity 100, all buffers empty.
module midi_controller_event_generator_core #(
  parameter int unsigned KEY_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  // scan items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // buttons[6:0], joy_x[22:7], joy_y[38:23], pad
  // event items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data1[6:0], data2[13:7], pad
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mceg_pkg::*;

  localparam int unsigned LANES = (KEY_COUNT < MASK_BITS) ? KEY_COUNT : MASK_BITS;
  localparam int unsigned NSLOT = LANES + 2;
  localparam int unsigned SLOT_BEND = LANES;
  localparam int unsigned SLOT_CC   = LANES + 1;

  // configuration registers
  logic [DZ_W-1:0]   deadband_r;
  logic [MIDI_W-1:0] velocity_r;
  logic              cfg_wr;

  // input register
  logic                     s0_valid_r;
  logic [MASK_BITS-1:0]     s0_buttons_r;
  logic signed [AXIS_W-1:0] s0_x_r, s0_y_r;
  logic                     s0_take;

  // scan state
  logic [LANES-1:0]  prev_buttons_r;
  logic [BEND_W-1:0] prev_bend_r;
  logic [MIDI_W-1:0] prev_mod_r;

  logic signed [AXIS_W-1:0] cond_x, cond_y;
  logic signed [AXIS_W:0]   bend_sum;
  logic [BEND_W-1:0]        bend;
  logic [AXIS_W-1:0]        x_off;
  logic [22:0]              mod_prod;
  logic [MIDI_W-1:0]        mod;

  lane_res_t        lane_res [LANES];
  logic [NSLOT-1:0] load_pend;
  evt_t             load_evt [NSLOT];
  logic             buf_free;
  evt_t             out_evt;

  // APB write and read
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
      velocity_r <= VELOCITY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_DEADBAND: deadband_r <= cfg_pwdata[DZ_W-1:0];
        REG_VELOCITY: velocity_r <= cfg_pwdata[MIDI_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DEADBAND: cfg_prdata = {17'd0, deadband_r};
      REG_VELOCITY: cfg_prdata = {25'd0, velocity_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // input register, emptied when the scan moves into the event buffer
  assign s0_take   = s0_valid_r && buf_free;
  assign in_tready = !s0_valid_r || s0_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_buttons_r <= in_tdata[6:0];
      s0_x_r       <= in_tdata[22:7];
      s0_y_r       <= in_tdata[38:23];
    end
  end

  // key lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mceg_key_lane #(.LANE_IDX(g)) u_lane (
      .cur      (s0_buttons_r[g]),
      .prev     (prev_buttons_r[g]),
      .velocity (velocity_r),
      .res      (lane_res[g])
    );
  end

  // joystick axes
  mceg_axis u_axis_x (.raw(s0_x_r), .deadband(deadband_r), .cond(cond_x));
  mceg_axis u_axis_y (.raw(s0_y_r), .deadband(deadband_r), .cond(cond_y));

  // bend = 8192 + floor(y/2), capped; modulation = (x+1.0)*127 >> 15
  always_comb begin
    bend_sum = 17'(cond_y >>> 1) + 17'(signed'({1'b0, BEND_CENTRE}));
    bend     = (bend_sum > 17'(signed'({1'b0, BEND_MAX}))) ? BEND_MAX[BEND_W-1:0]
                                                          : bend_sum[BEND_W-1:0];
    x_off    = 16'(cond_x + ONE_Q14);
    mod_prod = {x_off, 7'd0} - {7'd0, x_off};
    mod      = mod_prod[21:15];
  end

  // slot list: keys in index order, then bend, then modulation
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      load_pend[i] = lane_res[i].chg;
      load_evt[i]  = lane_res[i].evt;
    end
    load_pend[SLOT_BEND]      = (bend != prev_bend_r);
    load_evt[SLOT_BEND].kind  = KIND_BEND;
    load_evt[SLOT_BEND].data1 = bend[MIDI_W-1:0];
    load_evt[SLOT_BEND].data2 = bend[BEND_W-1:MIDI_W];
    load_pend[SLOT_CC]        = (mod != prev_mod_r);
    load_evt[SLOT_CC].kind    = KIND_CC;
    load_evt[SLOT_CC].data1   = CC_MODULATION;
    load_evt[SLOT_CC].data2   = mod;
  end

  // scan state follows each scan as it enters the buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_buttons_r <= '0;
      prev_bend_r    <= BEND_CENTRE;
      prev_mod_r     <= '0;
    end else if (s0_take) begin
      prev_buttons_r <= s0_buttons_r[LANES-1:0];
      prev_bend_r    <= bend;
      prev_mod_r     <= mod;
    end
  end

  mceg_merge #(.NSLOT(NSLOT)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s0_take),
    .load_pend (load_pend),
    .load_evt  (load_evt),
    .buf_free  (buf_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_evt   (out_evt),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_evt.data2, out_evt.data1};
  assign out_tuser = out_evt.kind;

  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !s0_take |=> s0_valid_r && $stable(s0_buttons_r) && $stable(s0_y_r))
    else $error("waiting scan item lost or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s0_valid_r |-> in_tready)
    else $error("empty input register refuses an item");

endmodule

### src/mceg_key_lane.sv
// ----------------------------------------------------------------------------
// mceg_key_lane
// One key: compares the new pressed state with the stored one and forms the
// note-on or note-off event.
// ----------------------------------------------------------------------------
module mceg_key_lane #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic                       cur,
  input  logic                       prev,
  input  logic [mceg_pkg::MIDI_W-1:0] velocity,
  output mceg_pkg::lane_res_t        res
);
  import mceg_pkg::*;

  // press gives note-on at the set velocity, release note-off at zero
  always_comb begin
    res.chg       = cur ^ prev;
    res.evt.kind  = cur ? KIND_NOTE_ON : KIND_NOTE_OFF;
    res.evt.data1 = key_note(LANE_IDX);
    res.evt.data2 = cur ? velocity : '0;
  end

endmodule

### src/mceg_axis.sv
// ----------------------------------------------------------------------------
// mceg_axis
// Joystick axis conditioning: dead zone, then clamp to +-1.0 (Q1.14).
// ----------------------------------------------------------------------------
module mceg_axis (
  input  logic signed [mceg_pkg::AXIS_W-1:0] raw,
  input  logic [mceg_pkg::DZ_W-1:0]          deadband,
  output logic signed [mceg_pkg::AXIS_W-1:0] cond
);
  import mceg_pkg::*;

  logic signed [AXIS_W:0] s_ext;
  logic [AXIS_W:0]        mag;

  // magnitude needs one extra bit for full-scale negative
  always_comb begin
    s_ext = {raw[AXIS_W-1], raw};
    mag   = s_ext[AXIS_W] ? 17'(-s_ext) : 17'(s_ext);
    if (mag <= {2'b00, deadband}) begin
      cond = '0;
    end else if (raw > ONE_Q14) begin
      cond = ONE_Q14;
    end else if (raw < MINUS_ONE_Q) begin
      cond = MINUS_ONE_Q;
    end else begin
      cond = raw;
    end
  end

endmodule

### src/mceg_merge.sv
// ----------------------------------------------------------------------------
// mceg_merge
// Event buffer and emitter: holds the events of one scan and sends them out one
// per cycle while out_ready allows, lowest slot first, via the output register.
// ----------------------------------------------------------------------------
module mceg_merge #(
  parameter int unsigned NSLOT = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [NSLOT-1:0]     load_pend,
  input  mceg_pkg::evt_t       load_evt [NSLOT],
  output logic                 buf_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mceg_pkg::evt_t       out_evt,
  output logic                 out_last
);
  import mceg_pkg::*;

  logic [NSLOT-1:0] pend_r, pend_nxt;
  logic [NSLOT-1:0] pick;
  logic [NSLOT-1:0] pend_after;
  logic [NSLOT-1:0] pend_left;
  evt_t             slot_r [NSLOT];
  evt_t             sel_evt;
  logic             found;
  logic             emit;
  logic             out_valid_r;
  evt_t             out_evt_r;
  logic             out_last_r;

  // lowest pending slot and its event
  always_comb begin
    pick    = '0;
    found   = 1'b0;
    sel_evt = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (pend_r[i] && !found) begin
        pick[i] = 1'b1;
        found   = 1'b1;
      end
      sel_evt = sel_evt | (pick[i] ? slot_r[i] : '0);
    end
  end

  // emit when the output register is free or being taken
  always_comb begin
    emit       = (|pend_r) && (!out_valid_r || out_ready);
    pend_left  = pend_r & ~pick;
    pend_after = emit ? pend_left : pend_r;
    buf_free   = (pend_after == '0);
    pend_nxt   = load ? load_pend : pend_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_r[i] <= load_evt[i];
      end
    end
    if (emit) begin
      out_evt_r  <= sel_evt;
      out_last_r <= (pend_left == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_evt_r;
  assign out_last  = out_last_r;

  a_pick_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(pick))
    else $error("emitter picked more than one slot");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) && !out_valid_r |=> out_valid_r)
    else $error("pending event not moved to free output register");

endmodule

### verif/midi_controller_event_generator_core_tb.sv
// ----------------------------------------------------------------------------
// midi_controller_event_generator_core_tb
// Self-checking bench for the MIDI controller event generator. Scan items go
// in through the input stream and every event item that comes out is matched,
// field by field, against a scan-to-event predictor kept inside the bench. A
// short table of directed scans and register writes comes first, then random
// scans over several dead zone / velocity settings with gaps on both streams
// and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module midi_controller_event_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mceg_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 16;      // output latency plus a full scan of events
  localparam int HOLD_CYCLES  = 300;     // long output hold-off
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [MIDI_W-1:0] KEY_NOTES [MASK_BITS] = '{
    7'd60, 7'd62, 7'd64, 7'd65, 7'd61, 7'd63, 7'd66
  };

  typedef struct {
    evt_kind_t         kind;
    logic [MIDI_W-1:0] data1;
    logic [MIDI_W-1:0] data2;
    logic              last;
  } midi_event_t;

  typedef enum {ROW_SCAN, ROW_WRITE} row_op_t;

  // One directed step: a scan (with its event count and first event where
  // they are obvious, n_typed < 0 otherwise) or a register write.
  typedef struct {
    row_op_t    op;
    logic       reg_sel;
    int         value;
    logic [6:0] keys;
    int         jx;
    int         jy;
    int         n_typed;
    evt_kind_t  kind;
    int         d1;
    int         d2;
  } scan_row_t;

  // Clock and DUT ports
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata    = '0;   // buttons[6:0], joy_x[22:7], joy_y[38:23], pad
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;          // data1[6:0], data2[13:7], pad
  logic [1:0]  out_tuser;          // kind[1:0]
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state and register copies
  logic [MASK_BITS-1:0] key_state   = '0;
  int                   bend_state  = 8192;
  int                   mod_state   = 0;
  logic [DZ_W-1:0]      deadband_q  = DEADBAND_RST;
  logic [MIDI_W-1:0]    velocity_q  = VELOCITY_RST;
  midi_event_t          expected_events[$];

  // Typed expectation travelling with the item on offer
  int                typed_n    = -1;
  evt_kind_t         typed_kind = KIND_NOTE_ON;
  logic [MIDI_W-1:0] typed_d1   = '0;
  logic [MIDI_W-1:0] typed_d2   = '0;

  // Receiver control
  logic ready_jitter = 1'b0;
  logic flood_go     = 1'b0;
  logic hold_off     = 1'b0;
  int   out_gap      = 0;

  int errors = 0;
  int cycles = 0;

  scan_row_t directed_rows [23] = '{
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,      0,      0,  1, KIND_CC,       1,  63},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h7F,      0,      0,  7, KIND_NOTE_ON,  60, 100},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,      0,      0,  7, KIND_NOTE_OFF, 60, 0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h7F,  32767,  32767,  9, KIND_NOTE_ON,  60, 100},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00, -32768, -32768,  9, KIND_NOTE_OFF, 60, 0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00, -32768, -32768,  0, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,    819,    819,  2, KIND_BEND,     0,  64},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,   -819,   -819,  0, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,    820,    820, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,   -820,   -821, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,  16384,  16384,  2, KIND_BEND,     127, 127},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00, -16384, -16384,  2, KIND_BEND,     0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,  16385, -16385,  1, KIND_CC,       1,  127},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h55,     -1,      1, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h2A,  12345, -12345, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_WRITE, REG_DEADBAND, 0,     7'h00,      0,      0, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_WRITE, REG_VELOCITY, 127,   7'h00,      0,      0, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h01,      1,     -1, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h01,      0,      0, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_WRITE, REG_DEADBAND, 16384, 7'h00,      0,      0, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_WRITE, REG_VELOCITY, 0,     7'h00,      0,      0, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h7F,  16384, -16384, -1, KIND_NOTE_ON,  0,  0},
    '{ROW_SCAN,  REG_DEADBAND, 0,     7'h00,  16385,  16385, -1, KIND_NOTE_ON,  0,  0}
  };

  midi_controller_event_generator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // Dead zone, then saturation at +-1.0
  function automatic int condition_axis(input logic signed [AXIS_W-1:0] raw);
    int s;
    int mag;
    s = int'(raw);
    mag = (s < 0) ? -s : s;
    if (mag <= int'(deadband_q)) return 0;
    if (s > int'(ONE_Q14)) s = int'(ONE_Q14);
    if (s < -int'(ONE_Q14)) s = -int'(ONE_Q14);
    return s;
  endfunction

  // Events caused by one scan, in emission order; updates the controller state
  function automatic int predict_scan(input logic [MASK_BITS-1:0] keys,
                                      input logic signed [AXIS_W-1:0] jx,
                                      input logic signed [AXIS_W-1:0] jy);
    int n;
    int x;
    int y;
    int bend;
    int modv;
    midi_event_t ev;
    n = 0;
    ev.last = 1'b0;
    for (int i = 0; i < MASK_BITS; i++) begin
      if (keys[i] != key_state[i]) begin
        ev.kind  = keys[i] ? KIND_NOTE_ON : KIND_NOTE_OFF;
        ev.data1 = KEY_NOTES[i];
        ev.data2 = keys[i] ? velocity_q : '0;
        expected_events.insert(expected_events.size(), ev);
        n++;
      end
    end
    key_state = keys;

    // pitch bend: centre plus half the axis, rounded down
    y = condition_axis(jy);
    bend = int'(BEND_CENTRE) + (y >>> 1);
    if (bend > 16383) bend = 16383;
    if (bend < 0) bend = 0;
    if (bend != bend_state) begin
      ev.kind  = KIND_BEND;
      ev.data1 = bend[6:0];
      ev.data2 = bend[13:7];
      expected_events.insert(expected_events.size(), ev);
      n++;
      bend_state = bend;
    end

    // modulation wheel from X
    x = condition_axis(jx);
    modv = ((x + 16384) * 127) >>> 15;
    if (modv > 127) modv = 127;
    if (modv != mod_state) begin
      ev.kind  = KIND_CC;
      ev.data1 = CC_MODULATION;
      ev.data2 = modv[6:0];
      expected_events.insert(expected_events.size(), ev);
      n++;
      mod_state = modv;
    end

    if (n > 0) expected_events[expected_events.size()-1].last = 1'b1;
    return n;
  endfunction

  // Random axis sample: repeats, dead zone edges, extremes and full range
  function automatic logic [AXIS_W-1:0] pick_axis(input logic [AXIS_W-1:0] prev,
                                                  input int dz);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'(prev);
      2, 3: begin
        v = dz + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      4: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = 32767;
          2: v = 16384;
          3: v = -16384;
          4: v = 16385;
          5: v = -16385;
          default: v = 0;
        endcase
      end
      5, 6: v = int'($urandom_range(0, 65535));
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [MASK_BITS-1:0] pick_keys(input logic [MASK_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2: return prev;
      3, 4, 5: return prev ^ (7'd1 << $urandom_range(0, 6));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Receiver: random stalls when enabled, long hold-off on request
  always @(posedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else if (ready_jitter && $urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      out_gap    <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    wait (flood_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Event checking and prediction at each accepted scan
  always @(posedge clk) begin : event_check
    midi_event_t want;
    int base;
    int n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t ns: event with nothing expected, kind %0d data1 %0d data2 %0d",
                   $time, out_tuser, out_tdata[6:0], out_tdata[13:7]);
        end else begin
          want = expected_events.pop_front();
          check_field("kind", int'(want.kind), int'(out_tuser));
          check_field("data1", int'(want.data1), int'(out_tdata[6:0]));
          check_field("data2", int'(want.data2), int'(out_tdata[13:7]));
          check_field("last", int'(want.last), int'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        base = expected_events.size();
        n = predict_scan(in_tdata[6:0], in_tdata[22:7], in_tdata[38:23]);
        if (typed_n >= 0) begin
          check_field("event count", typed_n, n);
          if (typed_n > 0 && n > 0) begin
            check_field("first kind", int'(typed_kind), int'(expected_events[base].kind));
            check_field("first data1", int'(typed_d1), int'(expected_events[base].data1));
            check_field("first data2", int'(typed_d2), int'(expected_events[base].data2));
          end
        end
      end
    end
  end

  // Offer one scan item and wait for it to be taken
  task automatic send_scan(input logic [MASK_BITS-1:0] keys, input logic [AXIS_W-1:0] jx,
                           input logic [AXIS_W-1:0] jy, input int n_typed,
                           input evt_kind_t k, input logic [MIDI_W-1:0] d1,
                           input logic [MIDI_W-1:0] d2);
    in_tvalid  <= 1'b1;
    in_tdata   <= {1'b0, jy, jx, keys};
    typed_n    <= n_typed;
    typed_kind <= k;
    typed_d1   <= d1;
    typed_d2   <= d2;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic rest_input(input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected event is out and the block has gone quiet
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write with read-back, only once the block is idle
  task automatic set_register(input logic reg_sel, input int value);
    settle_block();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == REG_DEADBAND) deadband_q = 15'(value);
    else velocity_q = 7'(value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("register read-back", value, int'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    scan_row_t row;
    logic [MASK_BITS-1:0] last_keys;
    logic [AXIS_W-1:0] last_jx;
    logic [AXIS_W-1:0] last_jy;
    int dz;
    int vel;
    int count;
    logic jitter;

    last_keys = '0;
    last_jx   = '0;
    last_jy   = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, reset register values first
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.op == ROW_WRITE) begin
        set_register(row.reg_sel, row.value);
      end else begin
        send_scan(row.keys, 16'(row.jx), 16'(row.jy), row.n_typed, row.kind,
                  7'(row.d1), 7'(row.d2));
        rest_input(pick_gap());
        last_keys = row.keys;
      end
    end

    // random phases: quiet streams, extremes, a flood against a held output
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin dz = int'(DEADBAND_RST); vel = int'(VELOCITY_RST); count = 30; jitter = 1'b0; end
        1: begin dz = 0; vel = 127; count = 30; jitter = 1'b1; end
        2: begin
          dz = int'($urandom_range(0, 16384)); vel = int'($urandom_range(0, 127));
          count = 25; jitter = 1'b1;
        end
        3: begin dz = 16384; vel = 0; count = 30; jitter = 1'b1; end
        default: begin
          dz = int'($urandom_range(0, 2000)); vel = int'($urandom_range(0, 127));
          count = 30; jitter = 1'b1;
        end
      endcase
      set_register(REG_DEADBAND, dz);
      set_register(REG_VELOCITY, vel);
      ready_jitter <= jitter;
      if (p == 2) flood_go <= 1'b1;
      for (int k = 0; k < count; k++) begin
        last_keys = pick_keys(last_keys);
        last_jx   = pick_axis(last_jx, dz);
        last_jy   = pick_axis(last_jy, dz);
        send_scan(last_keys, last_jx, last_jy, -1, KIND_NOTE_ON, '0, '0);
        rest_input((jitter && p != 2) ? pick_gap() : 0);
      end
    end

    settle_block();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
